// ===== rtl/i2cm_pkg.sv =====
// Shared types and constants for the I2C master transfer engine.
// No dependencies.
package i2cm_pkg;

  localparam int unsigned MAX_LEN_DEF = 255;
  localparam logic [15:0] QUARTER_RST = 16'd625;
  localparam logic [15:0] HALF_RST    = 16'd1250;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_HEADER = 2'd1;
  localparam logic [1:0] OP_WBYTE  = 2'd2;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_NACK  = 2'd2;
  localparam logic [1:0] ST_NOCFG = 2'd3;

  localparam logic [1:0] REG_QUARTER = 2'd0;
  localparam logic [1:0] REG_HALF    = 2'd1;
  localparam logic [1:0] REG_OD      = 2'd2;
  localparam logic [1:0] REG_EN      = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE, PH_HOLD, PH_WAIT_BYTE, PH_ST_A, PH_ST_B, PH_RS_A, PH_RS_B,
    PH_STOP_A, PH_STOP_B, PH_STOP_C, PH_BIT_A, PH_BIT_B, PH_BIT_C
  } phase_t;

  typedef enum logic [1:0] {THEN_START, THEN_OK, THEN_ERR} then_t;
  typedef enum logic [1:0] {KIND_ADDR, KIND_WRITE, KIND_READ} kind_t;

  typedef struct packed {
    logic [15:0] quarter_ticks;
    logic [15:0] half_ticks;
    logic        scl_release;
    logic        enabled;
  } cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] target_address;
    logic       read_flag;
    logic       restart_flag;
    logic       stop_flag;
    logic       first_message;
    logic       last_message;
    logic [7:0] length;
    logic [7:0] write_byte;
    logic       scl_level;
    logic       sda_level;
  } item_t;

  typedef struct packed {
    logic       scl_low;
    logic       scl_drive_high;
    logic       sda_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_byte;
    logic       busy_res;
    logic [1:0] status;
  } res_t;

endpackage

// ===== rtl/i2cm_cfg.sv =====
// Configuration register file for the I2C master engine.
// Depends on i2cm_pkg.
module i2cm_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output i2cm_pkg::cfg_t    cfg
);
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quarter_ticks <= i2cm_pkg::QUARTER_RST;
      cfg.half_ticks    <= i2cm_pkg::HALF_RST;
      cfg.scl_release   <= 1'b0;
      cfg.enabled       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::REG_QUARTER: cfg.quarter_ticks <= cfg_data;
        i2cm_pkg::REG_HALF:    cfg.half_ticks    <= cfg_data;
        i2cm_pkg::REG_OD:      cfg.scl_release   <= cfg_data[0];
        i2cm_pkg::REG_EN:      cfg.enabled       <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/i2cm_core.sv =====
// Bus phase sequencer: one tick in, next state and pin drives out.
// Depends on i2cm_pkg.
module i2cm_core #(
  parameter int unsigned MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  i2cm_pkg::cfg_t cfg,
  input  i2cm_pkg::item_t it,
  output i2cm_pkg::res_t res
);
  localparam logic [7:0] LEN_CAP = (MAX_LEN > 255) ? 8'd255 : 8'(MAX_LEN);

  i2cm_pkg::phase_t phase, phase_next;
  logic [15:0] tick_counter, tick_counter_next;
  logic [3:0]  bit_counter, bit_counter_next;
  logic [7:0]  shift_register, shift_register_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic        message_is_read, message_is_read_next;
  logic        message_is_last, message_is_last_next;
  logic        stop_pending, stop_pending_next;
  logic [6:0]  address_latched, address_latched_next;
  logic        scl_low, scl_low_next, scl_high, scl_high_next, sda_low, sda_low_next;
  i2cm_pkg::then_t stop_then, stop_then_next;
  i2cm_pkg::kind_t byte_kind, byte_kind_next;
  logic        ack_sample, ack_sample_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2cm_pkg::PH_IDLE;
      tick_counter <= '0; bit_counter <= '0; shift_register <= '0;
      bytes_left <= '0; message_is_read <= 1'b0; message_is_last <= 1'b0;
      stop_pending <= 1'b0; address_latched <= '0;
      scl_low <= 1'b0; scl_high <= 1'b0; sda_low <= 1'b0;
      stop_then <= i2cm_pkg::THEN_START; byte_kind <= i2cm_pkg::KIND_ADDR;
      ack_sample <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      tick_counter <= tick_counter_next; bit_counter <= bit_counter_next;
      shift_register <= shift_register_next; bytes_left <= bytes_left_next;
      message_is_read <= message_is_read_next;
      message_is_last <= message_is_last_next;
      stop_pending <= stop_pending_next; address_latched <= address_latched_next;
      scl_low <= scl_low_next; scl_high <= scl_high_next; sda_low <= sda_low_next;
      stop_then <= stop_then_next; byte_kind <= byte_kind_next;
      ack_sample <= ack_sample_next;
    end
  end

  logic [15:0] seg;
  logic        stretched;
  logic [15:0] tick_inc;
  logic        go_data;     // run data_next() on the updated state
  logic        entering;    // run enter() for phase_next
  logic [7:0]  len_sat;

  always_comb begin
    phase_next = phase; tick_counter_next = tick_counter;
    bit_counter_next = bit_counter; shift_register_next = shift_register;
    bytes_left_next = bytes_left; message_is_read_next = message_is_read;
    message_is_last_next = message_is_last; stop_pending_next = stop_pending;
    address_latched_next = address_latched;
    scl_low_next = scl_low; scl_high_next = scl_high; sda_low_next = sda_low;
    stop_then_next = stop_then; byte_kind_next = byte_kind;
    ack_sample_next = ack_sample;
    res.status = i2cm_pkg::ST_NONE; res.read_valid = 1'b0; res.read_byte = 8'd0;
    go_data = 1'b0; entering = 1'b0;

    len_sat = (it.length > LEN_CAP) ? LEN_CAP : it.length;
    seg = (phase == i2cm_pkg::PH_STOP_B || phase == i2cm_pkg::PH_STOP_C ||
           phase == i2cm_pkg::PH_BIT_B) ? cfg.half_ticks : cfg.quarter_ticks;
    if (seg == 16'd0) seg = 16'd1;
    stretched = cfg.scl_release && !it.scl_level &&
      (phase == i2cm_pkg::PH_RS_B || phase == i2cm_pkg::PH_STOP_B ||
       phase == i2cm_pkg::PH_BIT_B);
    tick_inc = tick_counter + 16'd1;

    if (phase == i2cm_pkg::PH_IDLE || phase == i2cm_pkg::PH_HOLD) begin
      if (it.op == i2cm_pkg::OP_HEADER) begin
        if (!cfg.enabled) begin
          res.status = i2cm_pkg::ST_NOCFG;
        end else begin
          address_latched_next = it.target_address;
          message_is_read_next = it.read_flag;
          message_is_last_next = it.last_message;
          bytes_left_next = len_sat;
          stop_pending_next = it.stop_flag;
          entering = 1'b1;
          if (phase == i2cm_pkg::PH_IDLE) phase_next = i2cm_pkg::PH_ST_A;
          else if (stop_pending) begin
            stop_then_next = i2cm_pkg::THEN_START; phase_next = i2cm_pkg::PH_STOP_A;
          end else if (it.first_message || it.restart_flag)
            phase_next = i2cm_pkg::PH_RS_A;
          else begin
            entering = 1'b0; go_data = 1'b1;
          end
        end
      end
    end else if (phase == i2cm_pkg::PH_WAIT_BYTE) begin
      if (it.op == i2cm_pkg::OP_WBYTE) begin
        shift_register_next = it.write_byte;
        byte_kind_next = i2cm_pkg::KIND_WRITE;
        bit_counter_next = 4'd0;
        phase_next = i2cm_pkg::PH_BIT_A; entering = 1'b1;
      end
    end else if (!stretched) begin
      tick_counter_next = tick_inc;
      if (tick_inc >= seg) begin
        entering = 1'b1;
        unique case (phase)
          i2cm_pkg::PH_ST_A: phase_next = i2cm_pkg::PH_ST_B;
          i2cm_pkg::PH_ST_B: begin
            shift_register_next = {address_latched, message_is_read};
            byte_kind_next = i2cm_pkg::KIND_ADDR;
            bit_counter_next = 4'd0;
            phase_next = i2cm_pkg::PH_BIT_A;
          end
          i2cm_pkg::PH_RS_A:   phase_next = i2cm_pkg::PH_RS_B;
          i2cm_pkg::PH_RS_B:   phase_next = i2cm_pkg::PH_ST_A;
          i2cm_pkg::PH_STOP_A: phase_next = i2cm_pkg::PH_STOP_B;
          i2cm_pkg::PH_STOP_B: phase_next = i2cm_pkg::PH_STOP_C;
          i2cm_pkg::PH_STOP_C: begin
            if (stop_then == i2cm_pkg::THEN_START) phase_next = i2cm_pkg::PH_ST_A;
            else begin
              entering = 1'b0;
              res.status = (stop_then == i2cm_pkg::THEN_OK) ? i2cm_pkg::ST_OK
                                                             : i2cm_pkg::ST_NACK;
              stop_pending_next = 1'b0;
              phase_next = i2cm_pkg::PH_IDLE;
              tick_counter_next = 16'd0;
            end
          end
          i2cm_pkg::PH_BIT_A: phase_next = i2cm_pkg::PH_BIT_B;
          i2cm_pkg::PH_BIT_B: begin
            if (byte_kind == i2cm_pkg::KIND_READ) begin
              if (bit_counter < 4'd8) begin
                shift_register_next = {shift_register[6:0], it.sda_level};
                if (bit_counter == 4'd7) begin
                  res.read_valid = 1'b1;
                  res.read_byte = shift_register_next;
                end
              end
            end else if (bit_counter == 4'd8) ack_sample_next = it.sda_level;
            phase_next = i2cm_pkg::PH_BIT_C;
          end
          i2cm_pkg::PH_BIT_C: begin
            if (bit_counter < 4'd8) begin
              bit_counter_next = bit_counter + 4'd1;
              phase_next = i2cm_pkg::PH_BIT_A;
            end else if (byte_kind != i2cm_pkg::KIND_READ && ack_sample) begin
              stop_then_next = i2cm_pkg::THEN_ERR;
              phase_next = i2cm_pkg::PH_STOP_A;
            end else begin
              entering = 1'b0;
              if (byte_kind != i2cm_pkg::KIND_ADDR && bytes_left != 8'd0)
                bytes_left_next = bytes_left - 8'd1;
              go_data = 1'b1;
            end
          end
          default: entering = 1'b0;
        endcase
      end
    end

    // data_next: choose what follows a finished byte or a header
    if (go_data) begin
      if (bytes_left_next == 8'd0) begin
        if (message_is_last_next) begin
          stop_then_next = i2cm_pkg::THEN_OK;
          phase_next = i2cm_pkg::PH_STOP_A; entering = 1'b1;
        end else phase_next = i2cm_pkg::PH_HOLD;
      end else if (message_is_read_next) begin
        byte_kind_next = i2cm_pkg::KIND_READ;
        shift_register_next = 8'd0;
        bit_counter_next = 4'd0;
        phase_next = i2cm_pkg::PH_BIT_A; entering = 1'b1;
      end else begin
        phase_next = i2cm_pkg::PH_WAIT_BYTE;
        tick_counter_next = 16'd0;
      end
    end

    // phase entry actions
    if (entering) begin
      tick_counter_next = 16'd0;
      case (phase_next)
        i2cm_pkg::PH_ST_A, i2cm_pkg::PH_STOP_A: sda_low_next = 1'b1;
        i2cm_pkg::PH_RS_A, i2cm_pkg::PH_STOP_C: sda_low_next = 1'b0;
        i2cm_pkg::PH_ST_B, i2cm_pkg::PH_BIT_C: begin
          scl_low_next = 1'b1; scl_high_next = 1'b0;
        end
        i2cm_pkg::PH_RS_B, i2cm_pkg::PH_STOP_B, i2cm_pkg::PH_BIT_B: begin
          scl_low_next = 1'b0; scl_high_next = !cfg.scl_release;
        end
        i2cm_pkg::PH_BIT_A: begin
          if (byte_kind_next == i2cm_pkg::KIND_READ)
            sda_low_next = (bit_counter_next == 4'd8) && (bytes_left_next > 8'd1);
          else if (bit_counter_next < 4'd8) begin
            sda_low_next = !shift_register_next[7];
            shift_register_next = {shift_register_next[6:0], 1'b0};
          end else sda_low_next = 1'b0;
        end
        default: ;
      endcase
    end

    res.scl_low = scl_low_next;
    res.scl_drive_high = scl_high_next;
    res.sda_low = sda_low_next;
    res.need_byte = (phase_next == i2cm_pkg::PH_WAIT_BYTE);
    res.busy_res = (phase_next != i2cm_pkg::PH_IDLE) && (phase_next != i2cm_pkg::PH_HOLD);
  end
endmodule

// ===== rtl/i2c_master_transfer_engine.sv =====
// Top level of the tick-driven I2C master transfer engine.
// Depends on i2cm_pkg, i2cm_cfg, i2cm_core.
//
// Usage: every input beat on s_axis is one timing tick carrying the sampled
// SCL/SDA levels plus an op: tick only, message header, or next write byte.
// Each accepted beat yields exactly one result beat on m_axis holding the pin
// drives, a received byte with its valid flag, need_byte, busy and status.
// The phase sequencer steps on acceptance and the result sits in an output
// register, valid on m_axis in the next cycle, at one beat per cycle while
// m_axis does not stall. s_axis_tready is high whenever the output register
// is empty or being drained in the same cycle, so a stall on m_axis holds the
// result and stops intake with no loss. Configuration registers are written
// through cfg_we/cfg_index/cfg_data by the user only while idle, unchecked by
// the block. Synchronous reset idles the sequencer with both lines released
// and loads default timing (625/1250 ticks, push-pull, disabled).
module i2c_master_transfer_engine #(
  parameter int unsigned MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[1:0], target_address[8:2], read_flag[9], restart_flag[10], stop_flag[11],
  // first_message[12], last_message[13], length[21:14], write_byte[29:22],
  // scl_level[30], sda_level[31]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scl_low[0], scl_drive_high[1], sda_low[2], read_byte[10:3], read_valid[11],
  // need_byte[12], busy_res[13], status[15:14]
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  i2cm_pkg::cfg_t  cfg;
  i2cm_pkg::item_t it;
  i2cm_pkg::res_t  res;
  logic            step;

  i2cm_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  always_comb begin
    it.op             = s_axis_tdata[1:0];
    it.target_address = s_axis_tdata[8:2];
    it.read_flag      = s_axis_tdata[9];
    it.restart_flag   = s_axis_tdata[10];
    it.stop_flag      = s_axis_tdata[11];
    it.first_message  = s_axis_tdata[12];
    it.last_message   = s_axis_tdata[13];
    it.length         = s_axis_tdata[21:14];
    it.write_byte     = s_axis_tdata[29:22];
    it.scl_level      = s_axis_tdata[30];
    it.sda_level      = s_axis_tdata[31];
  end

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign step = s_axis_tvalid && s_axis_tready;

  i2cm_core #(.MAX_LEN(MAX_LEN)) u_core (
    .clk(clk), .rst(rst), .step(step), .cfg(cfg), .it(it), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (s_axis_tready) m_axis_tvalid <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (step)
      m_axis_tdata <= {res.status, res.busy_res, res.need_byte, res.read_valid,
                       res.read_byte, res.sda_low, res.scl_drive_high, res.scl_low};
  end
endmodule
